// ----- hw/rtl/k_nearest_seed_shade_macros.svh -----
// Assertion helpers for the seed shader. The enclosing module must provide clk_i and rst_ni.
`ifndef K_NEAREST_SEED_SHADE_MACROS_SVH
`define K_NEAREST_SEED_SHADE_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define KNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define KNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/kns_pkg.sv -----
package kns_pkg;

  localparam int unsigned FUNC_W        = 2;
  localparam int unsigned FIELD_COORD_W = 10;
  localparam int unsigned FIELD_LEVEL_W = 8;
  localparam int unsigned COLOUR_W      = 8;
  localparam int unsigned FOUND_W       = 6;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned ORDER_W = 4;

  localparam int unsigned MAX_ORDER = 8;
  localparam int unsigned LIMB_W    = 16;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR  = 2'd0,
    FN_APPEND = 2'd1,
    FN_QUERY  = 2'd2
  } func_e;

  typedef enum logic [MODE_W-1:0] {
    MET_EUCLID    = 3'd0,
    MET_SQUARED   = 3'd1,
    MET_MANHATTAN = 3'd2,
    MET_MINKOWSKI = 3'd3,
    MET_CHEBYSHEV = 3'd4
  } metric_e;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_COUNT = 2'd1,
    REG_ORDER = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    DS_IDLE,
    DS_MUL,
    DS_NEXT,
    DS_SEARCH,
    DS_DONE
  } dist_state_e;

  typedef enum logic [1:0] {
    PH_X,
    PH_Y,
    PH_MID
  } phase_e;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_READ,
    TS_START,
    TS_DIST,
    TS_SUM,
    TS_DIV,
    TS_OUT
  } top_state_e;

  typedef struct packed {
    logic                 start;
    metric_e              metric;
    logic [ORDER_W-1:0]   order;
  } dist_req_t;

  typedef struct packed {
    logic clear;
    logic insert;
  } best_cmd_t;

endpackage

// ----- hw/rtl/kns_stream_if.sv -----
interface kns_in_if import kns_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [FIELD_COORD_W-1:0] point_x;
  logic [FIELD_COORD_W-1:0] point_y;
  logic [FIELD_LEVEL_W-1:0] seed_level;

  modport source (output valid, func, point_x, point_y, seed_level, input ready);
  modport sink   (input valid, func, point_x, point_y, seed_level, output ready);
endinterface

interface kns_out_if import kns_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COLOUR_W-1:0] colour_index;
  logic [FOUND_W-1:0]  neighbours_found;
  logic                store_overflowed;

  modport source (output valid, colour_index, neighbours_found, store_overflowed, input ready);
  modport sink   (input valid, colour_index, neighbours_found, store_overflowed, output ready);
endinterface

// ----- hw/rtl/kns_dist.sv -----
module kns_dist import kns_pkg::*; #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dist_req_t               req_i,
  input  logic [COORD_BITS-1:0]   dx_i,
  input  logic [COORD_BITS-1:0]   dy_i,
  output logic                    done_o,
  output logic [2*COORD_BITS:0]   dist_o
);

  localparam int unsigned RW  = COORD_BITS + 1;
  localparam int unsigned NL  = (MAX_ORDER * RW + LIMB_W - 1) / LIMB_W + 1;
  localparam int unsigned W   = NL * LIMB_W;
  localparam int unsigned LCW = $clog2(NL);
  localparam int unsigned DW  = 2 * COORD_BITS + 1;
  localparam int unsigned PW  = LIMB_W + RW;
  localparam logic [RW-1:0] ROOT_MAX = '1;

  dist_state_e            state_q, state_d;
  phase_e                 phase_q, phase_d;
  metric_e                metric_q, metric_d;
  logic [W-1:0]           acc_q, acc_d, sum_q, sum_d;
  logic [RW-1:0]          base_q, base_d, lo_q, lo_d, hi_q, hi_d, carry_q, carry_d;
  logic [LCW-1:0]         limb_q, limb_d;
  logic [ORDER_W-1:0]     pcnt_q, pcnt_d, order_q, order_d;
  logic [COORD_BITS-1:0]  dy_q, dy_d;
  logic [DW-1:0]          dist_q, dist_d;

  logic [PW-1:0]          prod;
  logic [RW:0]            span;
  logic [RW-1:0]          mid;
  logic [W-1:0]           sum_new;
  logic                   last_limb;
  logic                   fits;

  // One limb of the running product per cycle; the accumulator rotates right by a limb.
  assign prod      = PW'(acc_q[LIMB_W-1:0]) * PW'(base_q) + PW'(carry_q);
  assign span      = {1'b0, hi_q} - {1'b0, lo_q} + (RW+1)'(1);
  assign mid       = lo_q + span[RW:1];
  assign sum_new   = sum_q + acc_q;
  assign last_limb = (limb_q == LCW'(NL - 1));
  assign fits      = (acc_q <= sum_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DS_IDLE: begin
        if (req_i.start) begin
          if (req_i.metric == MET_MANHATTAN || req_i.metric == MET_CHEBYSHEV) begin
            state_d = DS_DONE;
          end else begin
            state_d = DS_MUL;
          end
        end
      end
      DS_MUL: begin
        if (last_limb && pcnt_q == ORDER_W'(1)) begin
          state_d = DS_NEXT;
        end
      end
      DS_NEXT: begin
        unique case (phase_q)
          PH_X:    state_d = DS_MUL;
          PH_Y:    state_d = (metric_q == MET_SQUARED) ? DS_DONE : DS_SEARCH;
          default: state_d = DS_SEARCH;
        endcase
      end
      DS_SEARCH: state_d = (lo_q < hi_q) ? DS_MUL : DS_DONE;
      default:   state_d = DS_IDLE;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    metric_d = metric_q;
    acc_d    = acc_q;
    sum_d    = sum_q;
    base_d   = base_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    carry_d  = carry_q;
    limb_d   = limb_q;
    pcnt_d   = pcnt_q;
    order_d  = order_q;
    dy_d     = dy_q;
    dist_d   = dist_q;
    case (state_q)
      DS_IDLE: begin
        if (req_i.start) begin
          metric_d = req_i.metric;
          order_d  = req_i.order;
          pcnt_d   = req_i.order;
          dy_d     = dy_i;
          acc_d    = W'(1);
          base_d   = RW'(dx_i);
          carry_d  = '0;
          limb_d   = '0;
          phase_d  = PH_X;
          if (req_i.metric == MET_MANHATTAN) begin
            dist_d = DW'(dx_i) + DW'(dy_i);
          end else begin
            dist_d = (dx_i > dy_i) ? DW'(dx_i) : DW'(dy_i);
          end
        end
      end
      DS_MUL: begin
        acc_d   = {prod[LIMB_W-1:0], acc_q[W-1:LIMB_W]};
        carry_d = prod[LIMB_W +: RW];
        if (last_limb) begin
          limb_d  = '0;
          carry_d = '0;
          pcnt_d  = pcnt_q - ORDER_W'(1);
        end else begin
          limb_d = limb_q + LCW'(1);
        end
      end
      DS_NEXT: begin
        case (phase_q)
          PH_X: begin
            sum_d   = acc_q;
            acc_d   = W'(1);
            base_d  = RW'(dy_q);
            pcnt_d  = order_q;
            phase_d = PH_Y;
          end
          PH_Y: begin
            sum_d  = sum_new;
            dist_d = sum_new[DW-1:0];
            lo_d   = '0;
            hi_d   = ROOT_MAX;
          end
          default: begin
            if (fits) begin
              lo_d = mid;
            end else begin
              hi_d = mid - RW'(1);
            end
          end
        endcase
      end
      DS_SEARCH: begin
        if (lo_q < hi_q) begin
          base_d  = mid;
          acc_d   = W'(1);
          pcnt_d  = order_q;
          phase_d = PH_MID;
        end else begin
          dist_d = DW'(lo_q);
        end
      end
      default: ;
    endcase
  end

  assign done_o = (state_q == DS_DONE);
  assign dist_o = dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q  <= phase_d;
    metric_q <= metric_d;
    acc_q    <= acc_d;
    sum_q    <= sum_d;
    base_q   <= base_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    carry_q  <= carry_d;
    limb_q   <= limb_d;
    pcnt_q   <= pcnt_d;
    order_q  <= order_d;
    dy_q     <= dy_d;
    dist_q   <= dist_d;
  end

endmodule

// ----- hw/rtl/kns_best.sv -----
module kns_best import kns_pkg::*; #(
  parameter int unsigned MAX_NEIGHBOURS = 32,
  parameter int unsigned DW             = 21,
  parameter int unsigned LEVEL_BITS     = 8,
  parameter int unsigned KW             = $clog2(MAX_NEIGHBOURS + 1),
  parameter int unsigned IW             = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  best_cmd_t             cmd_i,
  input  logic [DW-1:0]         dist_i,
  input  logic [LEVEL_BITS-1:0] level_i,
  input  logic [KW-1:0]         k_i,
  input  logic [IW-1:0]         rd_idx_i,
  output logic [LEVEL_BITS-1:0] rd_level_o,
  output logic [KW-1:0]         total_o
);

  logic [DW-1:0]         dist_q [MAX_NEIGHBOURS];
  logic [DW-1:0]         dist_d [MAX_NEIGHBOURS];
  logic [LEVEL_BITS-1:0] lvl_q  [MAX_NEIGHBOURS];
  logic [LEVEL_BITS-1:0] lvl_d  [MAX_NEIGHBOURS];
  logic [KW-1:0]         total_q, total_d;

  logic [MAX_NEIGHBOURS-1:0] lt, eq;
  logic [KW-1:0]             pos, last;
  logic                      take;

  always_comb begin
    for (int m = 0; m < MAX_NEIGHBOURS; m++) begin
      lt[m] = (KW'(m) < total_q) && (dist_q[m] < dist_i);
      eq[m] = (KW'(m) < total_q) && (dist_q[m] == dist_i);
    end
  end

  // The list is sorted and distinct, so the count of smaller entries is the slot.
  assign pos  = KW'($countones(lt));
  assign last = (total_q < k_i) ? total_q : k_i - KW'(1);
  assign take = cmd_i.insert && !(|eq) && (pos < k_i);

  always_comb begin
    dist_d  = dist_q;
    lvl_d   = lvl_q;
    total_d = total_q;
    if (cmd_i.clear) begin
      total_d = '0;
    end else if (take) begin
      for (int m = MAX_NEIGHBOURS - 1; m > 0; m--) begin
        if (KW'(m) > pos && KW'(m) <= last) begin
          dist_d[m] = dist_q[m-1];
          lvl_d[m]  = lvl_q[m-1];
        end
      end
      dist_d[pos[IW-1:0]] = dist_i;
      lvl_d[pos[IW-1:0]]  = level_i;
      if (total_q < k_i) begin
        total_d = total_q + KW'(1);
      end
    end
  end

  assign rd_level_o = lvl_q[rd_idx_i];
  assign total_o    = total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    lvl_q  <= lvl_d;
  end

endmodule

// ----- hw/rtl/k_nearest_seed_shade.sv -----
// Seed-point shader. Clear and append words are handled in the idle state and leave the block
// ready for the next word. A query word walks every stored seed through one shared distance unit
// that multiplies a 16-bit limb of a wide product per cycle, the product being
// L = ceil(8*(COORD_BITS+1)/16)+1 limbs (7 by default). Manhattan and Chebyshev need no multiplying;
// squared Euclidean raises dx and dy to the power p = 2, and floor Euclidean (p = 2) and Minkowski,
// p being the order in use, then search the root in eleven bisection steps. After the
// walk, the kept levels are summed one per cycle and divided by K bit-serially into a quotient of
// LEVEL_BITS plus clog2(MAX_NEIGHBOURS+1) bits. The block takes no word during a query; a finished
// result sits in an output register so the next word may be taken while it waits.
`include "k_nearest_seed_shade_macros.svh"

module k_nearest_seed_shade import kns_pkg::*; #(
  parameter int unsigned MAX_SEEDS      = 1024,
  parameter int unsigned MAX_NEIGHBOURS = 32,
  parameter int unsigned COORD_BITS     = 10,
  parameter int unsigned LEVEL_BITS     = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kns_in_if.sink            item_i,
  kns_out_if.source         result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned AW     = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int unsigned TW     = $clog2(MAX_SEEDS + 1);
  localparam int unsigned KW     = $clog2(MAX_NEIGHBOURS + 1);
  localparam int unsigned IW     = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam int unsigned DW     = 2 * COORD_BITS + 1;
  localparam int unsigned SW     = LEVEL_BITS + KW;
  localparam int unsigned DCW    = $clog2(SW + 1);
  localparam int unsigned SEED_W = 2 * COORD_BITS + LEVEL_BITS;
  localparam int unsigned CXW    = COUNT_W + KW;

  // Configuration registers.
  logic [MODE_W-1:0]  mode_q;
  logic [COUNT_W-1:0] count_q;
  logic [ORDER_W-1:0] order_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_W'(MET_EUCLID);
      count_q <= COUNT_W'(32);
      order_q <= ORDER_W'(4);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_MODE:  mode_q  <= pwdata[MODE_W-1:0];
        REG_COUNT: count_q <= pwdata[COUNT_W-1:0];
        REG_ORDER: order_q <= pwdata[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:  prdata = APB_DW'(mode_q);
      REG_COUNT: prdata = APB_DW'(count_q);
      REG_ORDER: prdata = APB_DW'(order_q);
      default:   prdata = '0;
    endcase
  end

  // Effective query settings.
  logic [CXW-1:0]     count_x;
  logic [KW-1:0]      k_eff;
  metric_e            metric_eff;
  logic [ORDER_W-1:0] order_eff;

  assign count_x = CXW'(count_q);

  always_comb begin
    if (count_x == '0) begin
      k_eff = KW'(1);
    end else if (count_x > CXW'(MAX_NEIGHBOURS)) begin
      k_eff = KW'(MAX_NEIGHBOURS);
    end else begin
      k_eff = count_x[KW-1:0];
    end
    metric_eff = (mode_q > MODE_W'(MET_CHEBYSHEV)) ? MET_EUCLID : metric_e'(mode_q);
    if (metric_eff == MET_EUCLID || metric_eff == MET_SQUARED) begin
      order_eff = ORDER_W'(2);
    end else if (order_q == '0) begin
      order_eff = ORDER_W'(1);
    end else if (order_q > ORDER_W'(MAX_ORDER)) begin
      order_eff = ORDER_W'(MAX_ORDER);
    end else begin
      order_eff = order_q;
    end
  end

  // Input word fields reduced to the configured widths.
  logic [COORD_BITS+FIELD_COORD_W-1:0] px_x, py_x;
  logic [LEVEL_BITS+FIELD_LEVEL_W-1:0] lvl_x;
  logic [COORD_BITS-1:0]               in_x, in_y;
  logic [LEVEL_BITS-1:0]               in_lvl;

  assign px_x   = (COORD_BITS+FIELD_COORD_W)'(item_i.point_x);
  assign py_x   = (COORD_BITS+FIELD_COORD_W)'(item_i.point_y);
  assign lvl_x  = (LEVEL_BITS+FIELD_LEVEL_W)'(item_i.seed_level);
  assign in_x   = px_x[COORD_BITS-1:0];
  assign in_y   = py_x[COORD_BITS-1:0];
  assign in_lvl = lvl_x[LEVEL_BITS-1:0];

  // Sequencer state.
  top_state_e             state_q, state_d;
  logic [TW-1:0]          seed_total_q, seed_total_d;
  logic                   ovf_q, ovf_d;
  logic [TW-1:0]          idx_q, idx_d;
  logic [COORD_BITS-1:0]  qx_q, qx_d, qy_q, qy_d;
  logic [KW-1:0]          k_q, k_d;
  metric_e                metric_q, metric_d;
  logic [ORDER_W-1:0]     ord_q, ord_d;
  logic [KW-1:0]          sidx_q, sidx_d;
  logic [SW-1:0]          sum_q, sum_d;
  logic [SW-1:0]          num_q, num_d;
  logic [KW-1:0]          rem_q, rem_d;
  logic [DCW-1:0]         dcnt_q, dcnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [COLOUR_W-1:0]    colour_q, colour_d;
  logic [FOUND_W-1:0]     found_q, found_d;
  logic                   out_ovf_q, out_ovf_d;

  logic                   accept;
  logic                   is_query;
  logic                   out_load;
  logic                   mem_we;
  logic [SEED_W-1:0]      seed_mem [MAX_SEEDS];
  logic [SEED_W-1:0]      rd_q;
  logic [COORD_BITS-1:0]  sx, sy, dx, dy;
  logic [LEVEL_BITS-1:0]  slvl;

  dist_req_t              dreq;
  logic                   dist_done;
  logic [DW-1:0]          dist_val;
  best_cmd_t              bcmd;
  logic [LEVEL_BITS-1:0]  best_lvl;
  logic [KW-1:0]          best_total;

  logic [KW:0]            trial;
  logic                   ge;
  logic [SW+COLOUR_W-1:0] quo_x;
  logic [KW+FOUND_W-1:0]  found_x;

  assign item_i.ready = (state_q == TS_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign is_query     = accept && (item_i.func == FN_QUERY);
  assign out_load     = (state_q == TS_OUT) && (!out_valid_q || result_o.ready);
  assign mem_we       = accept && (item_i.func == FN_APPEND) &&
                        (seed_total_q < TW'(MAX_SEEDS));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seed_mem[seed_total_q[AW-1:0]] <= {in_x, in_y, in_lvl};
    end
    if (state_q == TS_READ) begin
      rd_q <= seed_mem[idx_q[AW-1:0]];
    end
  end

  assign sx   = rd_q[SEED_W-1 -: COORD_BITS];
  assign sy   = rd_q[LEVEL_BITS +: COORD_BITS];
  assign slvl = rd_q[LEVEL_BITS-1:0];
  assign dx   = (qx_q > sx) ? qx_q - sx : sx - qx_q;
  assign dy   = (qy_q > sy) ? qy_q - sy : sy - qy_q;

  assign dreq.start  = (state_q == TS_START);
  assign dreq.metric = metric_q;
  assign dreq.order  = ord_q;

  kns_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .dx_i   (dx),
    .dy_i   (dy),
    .done_o (dist_done),
    .dist_o (dist_val)
  );

  assign bcmd.clear  = is_query;
  assign bcmd.insert = (state_q == TS_DIST) && dist_done;

  kns_best #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
    .DW             (DW),
    .LEVEL_BITS     (LEVEL_BITS),
    .KW             (KW),
    .IW             (IW)
  ) u_best (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (bcmd),
    .dist_i     (dist_val),
    .level_i    (slvl),
    .k_i        (k_q),
    .rd_idx_i   (sidx_q[IW-1:0]),
    .rd_level_o (best_lvl),
    .total_o    (best_total)
  );

  // Restoring division step: remainder stays below K.
  assign trial   = {rem_q, num_q[SW-1]};
  assign ge      = trial >= {1'b0, k_q};
  assign quo_x   = (SW+COLOUR_W)'(num_q);
  assign found_x = (KW+FOUND_W)'(best_total);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TS_IDLE: begin
        if (is_query) begin
          state_d = (seed_total_q == '0) ? TS_SUM : TS_READ;
        end
      end
      TS_READ:  state_d = TS_START;
      TS_START: state_d = TS_DIST;
      TS_DIST: begin
        if (dist_done) begin
          state_d = (idx_q + TW'(1) == seed_total_q) ? TS_SUM : TS_READ;
        end
      end
      TS_SUM: begin
        if (sidx_q >= best_total) begin
          state_d = TS_DIV;
        end
      end
      TS_DIV: begin
        if (dcnt_q == DCW'(SW - 1)) begin
          state_d = TS_OUT;
        end
      end
      default: begin
        if (out_load) begin
          state_d = TS_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    seed_total_d = seed_total_q;
    ovf_d        = ovf_q;
    idx_d        = idx_q;
    qx_d         = qx_q;
    qy_d         = qy_q;
    k_d          = k_q;
    metric_d     = metric_q;
    ord_d        = ord_q;
    sidx_d       = sidx_q;
    sum_d        = sum_q;
    num_d        = num_q;
    rem_d        = rem_q;
    dcnt_d       = dcnt_q;
    out_valid_d  = out_valid_q;
    colour_d     = colour_q;
    found_d      = found_q;
    out_ovf_d    = out_ovf_q;

    if (result_o.valid && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      TS_IDLE: begin
        if (accept) begin
          case (item_i.func)
            FN_CLEAR: begin
              seed_total_d = '0;
              ovf_d        = 1'b0;
            end
            FN_APPEND: begin
              if (mem_we) begin
                seed_total_d = seed_total_q + TW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            FN_QUERY: begin
              qx_d     = in_x;
              qy_d     = in_y;
              k_d      = k_eff;
              metric_d = metric_eff;
              ord_d    = order_eff;
              idx_d    = '0;
              sidx_d   = '0;
              sum_d    = '0;
            end
            default: ;
          endcase
        end
      end
      TS_DIST: begin
        if (dist_done) begin
          idx_d = idx_q + TW'(1);
        end
      end
      TS_SUM: begin
        if (sidx_q < best_total) begin
          sum_d  = sum_q + SW'(best_lvl);
          sidx_d = sidx_q + KW'(1);
        end else begin
          num_d  = sum_q;
          rem_d  = '0;
          dcnt_d = '0;
        end
      end
      TS_DIV: begin
        rem_d  = ge ? KW'(trial - {1'b0, k_q}) : trial[KW-1:0];
        num_d  = {num_q[SW-2:0], ge};
        dcnt_d = dcnt_q + DCW'(1);
      end
      TS_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          colour_d    = (quo_x > (SW+COLOUR_W)'(255)) ? COLOUR_W'(255) : quo_x[COLOUR_W-1:0];
          found_d     = found_x[FOUND_W-1:0];
          out_ovf_d   = ovf_q;
        end
      end
      default: ;
    endcase
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.colour_index     = colour_q;
  assign result_o.neighbours_found = found_q;
  assign result_o.store_overflowed = out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= TS_IDLE;
      seed_total_q <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      seed_total_q <= seed_total_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    qx_q      <= qx_d;
    qy_q      <= qy_d;
    k_q       <= k_d;
    metric_q  <= metric_d;
    ord_q     <= ord_d;
    sidx_q    <= sidx_d;
    sum_q     <= sum_d;
    num_q     <= num_d;
    rem_q     <= rem_d;
    dcnt_q    <= dcnt_d;
    colour_q  <= colour_d;
    found_q   <= found_d;
    out_ovf_q <= out_ovf_d;
  end

  `KNS_ASSERT(a_store_bound, seed_total_q <= TW'(MAX_SEEDS), "seed count above store depth")
  `KNS_ASSERT(a_kept_bound, (state_q != TS_IDLE) |-> (best_total <= k_q), "kept count above K")
  `KNS_ASSERT_NEXT(a_out_load, out_load, result_o.valid, "loaded result not presented")

endmodule
